[sv/bqld_pkg.sv]
`timescale 1ns / 1ps
// shared types, fixed-point constants and the coefficient table build for the
// biquad lowpass decimator; no dependencies
package bqld_pkg;

	localparam int COEF_FRAC = 30;
	localparam int MAX_SECT = 8;
	localparam int TABLE_SECT = 6;
	localparam int TAPS = 5;
	localparam int HIST_W = 32;
	localparam int OUT_W = 24;

	// volts scale: x = round(sample * 33 * 2^24 / (10 * 2^bits))
	localparam int VOLT_FRAC = 24;
	localparam int CONV_W = 31;
	localparam logic [CONV_W-1:0] VOLT_NUM = CONV_W'(33);
	localparam logic [CONV_W-1:0] HALF_TEN = CONV_W'(5);
	// ceil(2^35 / 10), exact floor division by ten for 32-bit operands
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int RECIP_SH = 35;

	typedef logic signed [HIST_W-1:0] hist_t;
	typedef logic signed [31:0] coef_t;
	typedef coef_t [MAX_SECT-1:0][TAPS-1:0] coef_tab_t;

	// gains over 1e12, denominator magnitudes over 1e10
	localparam longint unsigned GAIN_DEN = 64'd1000000000000;
	localparam longint unsigned POLE_DEN = 64'd10000000000;
	localparam longint unsigned GAIN_DEC [TABLE_SECT] = '{
		64'd10436200540, 64'd9894934483, 64'd9464552626,
		64'd9154595435, 64'd8968281560, 64'd94372585420
	};
	localparam longint unsigned DEN1_DEC [TABLE_SECT] = '{
		64'd19012445210, 64'd18026378150, 64'd17242317200,
		64'd16677644250, 64'd16338222030, 64'd8112547994
	};
	localparam longint unsigned DEN2_DEC [TABLE_SECT] = '{
		64'd9429892898, 64'd8422175050, 64'd7620899677,
		64'd7043827772, 64'd6696953177, 64'd0
	};
	localparam int TAP_W0 [TABLE_SECT] = '{1, 1, 1, 1, 1, 1};
	localparam int TAP_W1 [TABLE_SECT] = '{2, 2, 2, 2, 2, 1};
	localparam int TAP_W2 [TABLE_SECT] = '{1, 1, 1, 1, 1, 0};

	// round(num * 2^30 / den), halves up, by restoring long division; num < 2 * den
	function automatic longint unsigned to_fixed(longint unsigned num, longint unsigned den);
		longint unsigned res;
		longint unsigned rem;
		res = (num >= den) ? 64'd1 : 64'd0;
		rem = (num >= den) ? num - den : num;
		for (int i = 0; i < COEF_FRAC; i++) begin
			res = res << 1;
			rem = rem << 1;
			if (rem >= den) begin
				rem = rem - den;
				res = res | 64'd1;
			end
		end
		if ((rem << 1) >= den) begin
			res = res + 64'd1;
		end
		return res;
	endfunction

	// taps per section: b0, b1, b2, a1, a2 (feedback taps already negated)
	function automatic coef_tab_t build_coefs();
		coef_tab_t t;
		longint g;
		longint p1;
		longint p2;
		t = '0;
		for (int s = 0; s < MAX_SECT; s++) begin
			if (s < TABLE_SECT) begin
				g = longint'(to_fixed(GAIN_DEC[s], GAIN_DEN));
				p1 = longint'(to_fixed(DEN1_DEC[s], POLE_DEN));
				p2 = longint'(to_fixed(DEN2_DEC[s], POLE_DEN));
				t[s][0] = 32'(longint'(TAP_W0[s]) * g);
				t[s][1] = 32'(longint'(TAP_W1[s]) * g);
				t[s][2] = 32'(longint'(TAP_W2[s]) * g);
				t[s][3] = 32'(p1);
				t[s][4] = 32'(-p2);
			end else begin
				// pass-through section
				t[s][0] = 32'sh4000_0000;
			end
		end
		return t;
	endfunction

endpackage

[sv/biquad_lowpass_decimator_top.sv]
`timescale 1ns / 1ps
// an accepted sample is scaled, divided by ten in the RECIP and SCALE states, filtered section
// by section (FILT) and, on a decimation hit, emitted from FIN, which waits out output
// stalls; samples enter only in IDLE; sections share the history memory and 32x32 multiplier
// reset: asynchronous, clears the history (per-entry valid bits), the decimation counter,
// and loads a decimation factor of 10; no clearing pass, a sample may enter right away
// depends on bqld_pkg
module biquad_lowpass_decimator_top #(
	parameter int SECTIONS = 6,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [7:0]             cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [23:0]     filtered_volts
);
	import bqld_pkg::*;

	localparam int DEPTH = 4 * SECTIONS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int SCALE_SH = VOLT_FRAC - SAMPLE_BITS;
	localparam int ACC_W = 67;
	localparam coef_tab_t COEFS = build_coefs();

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RECIP = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_FILT  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam logic [2:0] PH_LAST = 3'd5;

	logic [2:0]            state_q;
	logic [SEC_W-1:0]      sec_q;
	logic [2:0]            ph_q;
	logic [7:0]            factor_q;
	logic [7:0]            count_q;
	logic                  emit_q;
	logic                  out_valid_q;
	logic signed [OUT_W-1:0] fv_q;

	logic [CONV_W-1:0]     conv_q;
	logic [CONV_W+31:0]    recip_s1;
	hist_t                 x_q;
	hist_t                 h0_q;
	hist_t                 h2_q;
	logic signed [63:0]    prod_s1;
	logic signed [ACC_W-1:0] acc_q;

	hist_t                 mem [DEPTH];
	logic [DEPTH-1:0]      vld_q;
	hist_t                 rdata_q;
	logic                  rvld_q;

	logic                  in_xfer;
	logic                  out_free;
	logic [7:0]            count_inc;
	logic [CONV_W-1:0]     conv_d;
	logic [ADDR_W-1:0]     base;
	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	logic                  wen;
	hist_t                 wdata;
	hist_t                 hdata;
	coef_t                 coef_op;
	hist_t                 data_op;
	logic signed [63:0]    prod_d;
	logic signed [ACC_W-1:0] sum_y;
	logic signed [ACC_W-COEF_FRAC-1:0] y_full;
	hist_t                 y_sat;
	logic signed [32:0]    o_sum;
	logic signed [28:0]    o_full;
	logic signed [OUT_W-1:0] o_sat;
	logic                  filt;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign filtered_volts = fv_q;
	assign out_free = !out_valid_q || !out_stall;
	assign count_inc = count_q + 8'd1;
	assign conv_d = (CONV_W'(adc_sample) * VOLT_NUM) << SCALE_SH;
	assign filt = (state_q == ST_FILT);

	// history layout per section: x1, x2, y1, y2
	assign base = ADDR_W'(sec_q) << 2;
	assign raddr = base + ADDR_W'(ph_q[1:0]);
	assign hdata = rvld_q ? rdata_q : '0;

	always_comb begin
		wen = 1'b0;
		waddr = base;
		wdata = x_q;
		if (filt) begin
			case (ph_q)
				3'd2: begin
					wen = 1'b1;
					waddr = base + ADDR_W'(1);
					wdata = h0_q;
				end
				3'd3: begin
					wen = 1'b1;
					waddr = base;
					wdata = x_q;
				end
				3'd4: begin
					wen = 1'b1;
					waddr = base + ADDR_W'(3);
					wdata = h2_q;
				end
				PH_LAST: begin
					wen = 1'b1;
					waddr = base + ADDR_W'(2);
					wdata = y_sat;
				end
				default: begin
					wen = 1'b0;
				end
			endcase
		end
	end

	// tap p multiplies x for p = 0, else the history word read in the previous cycle
	always_comb begin
		coef_op = '0;
		if (ph_q <= 3'd4) begin
			coef_op = $signed(COEFS[3'(sec_q)][ph_q]);
		end
		data_op = (ph_q == 3'd0) ? x_q : hdata;
	end
	assign prod_d = coef_op * data_op;

	// round to nearest, floor shift by the coefficient fraction, saturate to 32 bits
	assign sum_y = acc_q + ACC_W'(prod_s1) + (ACC_W'(1) <<< (COEF_FRAC - 1));
	assign y_full = $signed(sum_y[ACC_W-1:COEF_FRAC]);
	always_comb begin
		if (y_full > $signed(ACC_W'(32'h7FFF_FFFF))) begin
			y_sat = 32'sh7FFF_FFFF;
		end else if (y_full < -$signed(ACC_W'(33'h0_8000_0000))) begin
			y_sat = 32'sh8000_0000;
		end else begin
			y_sat = hist_t'(y_full);
		end
	end

	assign o_sum = 33'(x_q) + 33'sd8;
	assign o_full = $signed(o_sum[32:4]);
	always_comb begin
		if (o_full > 29'sd8388607) begin
			o_sat = 24'sh7F_FFFF;
		end else if (o_full < -29'sd8388608) begin
			o_sat = 24'sh80_0000;
		end else begin
			o_sat = o_full[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wen) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			conv_q <= conv_d + HALF_TEN;
		end
		recip_s1 <= conv_q * RECIP_TEN;
		prod_s1 <= prod_d;
		if (state_q == ST_SCALE) begin
			x_q <= hist_t'(recip_s1[CONV_W+31:RECIP_SH]);
		end else if (filt && ph_q == PH_LAST) begin
			x_q <= y_sat;
		end
		if (filt && ph_q == 3'd1) begin
			h0_q <= hdata;
			acc_q <= ACC_W'(prod_s1);
		end else if (filt && (ph_q == 3'd2 || ph_q == 3'd3 || ph_q == 3'd4)) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (filt && ph_q == 3'd3) begin
			h2_q <= hdata;
		end
		if (state_q == ST_FIN && emit_q && out_free) begin
			fv_q <= o_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q <= '0;
			ph_q <= '0;
			factor_q <= 8'd10;
			count_q <= '0;
			emit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				factor_q <= cfg_wdata;
			end
			// load a new result, or drop valid once the transfer is taken
			if (state_q == ST_FIN && emit_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						// counter steps before filtering; factor zero acts as one
						emit_q <= (count_inc >= factor_q);
						count_q <= (count_inc >= factor_q) ? 8'd0 : count_inc;
						state_q <= ST_RECIP;
					end
				end
				ST_RECIP: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					sec_q <= '0;
					ph_q <= '0;
					state_q <= ST_FILT;
				end
				ST_FILT: begin
					if (ph_q == PH_LAST) begin
						ph_q <= '0;
						if (sec_q == SEC_W'(SECTIONS - 1)) begin
							state_q <= ST_FIN;
						end else begin
							sec_q <= sec_q + SEC_W'(1);
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_FIN: begin
					if (!emit_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[verif/bqld_volts_checker.sv]
`timescale 1ns / 1ps
// output checker for the biquad lowpass decimator: follows every sample and config
// transfer, predicts the decimated filtered volts and compares them as they leave
// stand-alone, no package or rtl dependencies
module bqld_volts_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [11:0]        adc_sample,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [23:0] filtered_volts,
	output int                 volts_pending,
	output int                 mismatch_count
);

	localparam int NSECT = 6;
	localparam int QBITS = 30;

	// section gains scaled by 1e12, denominator magnitudes scaled by 1e10
	localparam longint unsigned GAIN_E12 [NSECT] = '{
		64'd10436200540, 64'd9894934483, 64'd9464552626,
		64'd9154595435, 64'd8968281560, 64'd94372585420
	};
	localparam longint unsigned POLE1_E10 [NSECT] = '{
		64'd19012445210, 64'd18026378150, 64'd17242317200,
		64'd16677644250, 64'd16338222030, 64'd8112547994
	};
	localparam longint unsigned POLE2_E10 [NSECT] = '{
		64'd9429892898, 64'd8422175050, 64'd7620899677,
		64'd7043827772, 64'd6696953177, 64'd0
	};
	localparam int WEIGHT0 [NSECT] = '{1, 1, 1, 1, 1, 1};
	localparam int WEIGHT1 [NSECT] = '{2, 2, 2, 2, 2, 1};
	localparam int WEIGHT2 [NSECT] = '{1, 1, 1, 1, 1, 0};

	localparam longint unsigned E12 = 64'd1000000000000;
	localparam longint unsigned E10 = 64'd10000000000;

	longint b0c [NSECT];
	longint b1c [NSECT];
	longint b2c [NSECT];
	longint a1c [NSECT];
	longint a2c [NSECT];

	// per section: x[n-1], x[n-2], y[n-1], y[n-2]
	logic signed [31:0] hist [NSECT][4];
	logic [7:0] sample_count;
	logic [7:0] ratio;
	logic signed [23:0] volts_due [$];
	logic signed [23:0] want;
	longint filt_out;
	int errors;

	// round(num * 2^30 / den), halves up, done wide so nothing overflows
	function automatic longint q30(longint unsigned num, longint unsigned den);
		logic [127:0] top2;
		logic [127:0] den2;
		top2 = (128'(num) << (QBITS + 1)) + 128'(den);
		den2 = 128'(den) << 1;
		return longint'(top2 / den2);
	endfunction

	function automatic logic signed [23:0] to_volts(longint y);
		longint v;
		v = (y + 64'sd8) >>> 4;
		if (v > 64'sd8388607)
			v = 64'sd8388607;
		else if (v < -64'sd8388608)
			v = -64'sd8388608;
		return 24'(v);
	endfunction

	task automatic advance_filter(input logic [11:0] code, output longint y_last);
		longint x;
		longint acc;
		longint y;
		// code * 3.3 / 4096 volts, 24 fraction bits, halves up
		x = (longint'(code) * 64'sd33 * (64'sd1 << 24) + 64'sd20480) / 64'sd40960;
		for (int s = 0; s < NSECT; s++) begin
			acc = b0c[s] * x + b1c[s] * longint'(hist[s][0]) + b2c[s] * longint'(hist[s][1])
				+ a1c[s] * longint'(hist[s][2]) + a2c[s] * longint'(hist[s][3]);
			y = (acc + (64'sd1 << (QBITS - 1))) >>> QBITS;
			if (y > 64'sd2147483647)
				y = 64'sd2147483647;
			else if (y < -64'sd2147483648)
				y = -64'sd2147483648;
			hist[s][1] = hist[s][0];
			hist[s][0] = 32'(x);
			hist[s][3] = hist[s][2];
			hist[s][2] = 32'(y);
			x = y;
		end
		y_last = x;
	endtask

	initial begin
		longint g;
		for (int s = 0; s < NSECT; s++) begin
			g = q30(GAIN_E12[s], E12);
			b0c[s] = longint'(WEIGHT0[s]) * g;
			b1c[s] = longint'(WEIGHT1[s]) * g;
			b2c[s] = longint'(WEIGHT2[s]) * g;
			// feedback taps carry the negated denominator terms
			a1c[s] = q30(POLE1_E10[s], E10);
			a2c[s] = -q30(POLE2_E10[s], E10);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NSECT; s++) begin
				for (int k = 0; k < 4; k++) begin
					hist[s][k] = '0;
				end
			end
			sample_count = '0;
			ratio = 8'd10;
			volts_due.delete();
			errors = 0;
			volts_pending <= 0;
			mismatch_count <= 0;
		end else begin
			// check the outgoing transfer before queueing anything new this edge
			if (out_valid && !out_stall) begin
				if (volts_due.size() == 0) begin
					$error("filtered_volts: no result expected, got %0d", filtered_volts);
					errors++;
				end else begin
					want = volts_due[0];
					volts_due.delete(0);
					if (filtered_volts !== want) begin
						$error("filtered_volts: expected %0d, got %0d", want, filtered_volts);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				advance_filter(adc_sample, filt_out);
				sample_count = sample_count + 8'd1;
				// a factor of zero behaves like one; a lowered factor fires at once
				if (sample_count >= ratio) begin
					sample_count = '0;
					volts_due.push_back(to_volts(filt_out));
				end
			end
			if (cfg_wen) begin
				ratio = cfg_wdata;
			end
			volts_pending <= volts_due.size();
			mismatch_count <= errors;
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// testbench top for biquad_lowpass_decimator_top: drives samples with gaps and decimation factors,
// shapes receiver stalls and gives the verdict; depends on the rtl and bqld_volts_checker
module tb_top;

	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 300;
	// longest quiet stretch in a good run is the hold-off plus the filtering of a sample
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_RAIL,
		SHAPE_SQUARE,
		SHAPE_MIDSCALE
	} shape_e;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_e;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [7:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [11:0] adc_sample;
	logic out_valid;
	logic out_stall;
	logic signed [23:0] filtered_volts;

	int volts_pending;
	int mismatch_count;
	int quiet_cycles;
	bit hold_off_req;
	bit hold_off_done;

	biquad_lowpass_decimator_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_volts (filtered_volts)
	);

	bqld_volts_checker volts_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_volts (filtered_volts),
		.volts_pending  (volts_pending),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic put_sample(input logic [11:0] code);
		in_valid <= 1'b1;
		adc_sample <= code;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// wait for the block to go idle: all results out, plus time for a silent sample
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (volts_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_ratio(input logic [7:0] factor);
		settle();
		cfg_wen <= 1'b1;
		cfg_wdata <= factor;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_phase(input int count);
		int sent;
		int burst;
		int gap;
		int half;
		int k;
		logic [11:0] rail;
		logic [11:0] code;
		shape_e shape;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			shape = shape_e'($urandom_range(0, 3));
			half = $urandom_range(1, 12);
			rail = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			for (k = 0; k < burst && sent < count; k++) begin
				case (shape)
					SHAPE_NOISE: code = 12'($urandom_range(0, 4095));
					SHAPE_RAIL: code = rail;
					SHAPE_SQUARE: code = ((k / half) % 2) ? 12'hFFF : 12'h000;
					default: code = 12'(2016 + $urandom_range(0, 64));
				endcase
				put_sample(code);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver: stall patterns in stretches, plus one long hold-off on request
	initial begin
		int stretch;
		stall_e pattern;
		out_stall <= 1'b0;
		forever begin
			if (hold_off_req && !hold_off_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end
			stretch = $urandom_range(8, 64);
			pattern = stall_e'($urandom_range(0, 3));
			repeat (stretch) begin
				case (pattern)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("biquad_lowpass_decimator_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		adc_sample <= '0;
		hold_off_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset factor of ten: rails and alternating bits, one result on the tenth
		put_sample(12'hFFF);
		put_sample(12'h000);
		put_sample(12'hFFF);
		put_sample(12'h000);
		put_sample(12'hAAA);
		put_sample(12'h555);
		put_sample(12'hFFF);
		put_sample(12'hFFF);
		put_sample(12'hFFF);
		put_sample(12'h000);

		// leave the count at seven, then drop the factor below it
		put_sample(12'h800);
		put_sample(12'h001);
		put_sample(12'hFFE);
		put_sample(12'h7FF);
		put_sample(12'hFFF);
		put_sample(12'h000);
		put_sample(12'h800);
		set_ratio(8'd3);
		put_sample(12'hFFF);

		// zero factor emits on every sample
		set_ratio(8'd0);
		put_sample(12'h000);
		put_sample(12'hFFF);
		put_sample(12'h001);
		put_sample(12'hFFE);

		// every sample emits here, so the long receiver hold-off backs up the input
		set_ratio(8'd1);
		hold_off_req = 1'b1;
		run_phase(150);
		set_ratio(8'd255);
		run_phase(300);
		set_ratio(8'd0);
		run_phase(100);
		set_ratio(8'd7);
		run_phase(150);
		set_ratio(8'($urandom_range(2, 254)));
		run_phase(125);
		set_ratio(8'($urandom_range(1, 20)));
		run_phase(125);

		settle();
		if (mismatch_count == 0 && volts_pending == 0) begin
			$display("biquad_lowpass_decimator_top test passed");
		end else begin
			$display("biquad_lowpass_decimator_top test failed");
		end
		$finish;
	end

endmodule
